// File: hw/rtl/lsrs_pkg.sv
// ----------------------------------------------------------------------------
// lsrs_pkg
// Shared types and constants of the loop sense relay sequencer.
// ----------------------------------------------------------------------------
package lsrs_pkg;

  localparam int unsigned RawW     = 12;  // converter sample
  localparam int unsigned MvW      = 12;  // millivolt value
  localparam int unsigned TickW    = 16;
  localparam int unsigned AccW     = 18;
  localparam int unsigned SmpCntW  = 7;
  localparam int unsigned ShiftW   = 3;
  localparam int unsigned PhaseW   = 2;
  localparam int unsigned NumSlots = 4;

  // floor(raw * 804 / 1000) == (raw * MvMul) >> MvShift for every 12-bit raw
  localparam int unsigned MvShift  = 24;
  localparam logic [MvShift-1:0] MvMul = 24'd13488882;

  localparam logic [ShiftW-1:0] MaxShift = 3'd6;

  // APB register map
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [1:0] {
    RegRelayDelay   = 2'd0,
    RegSettlePeriod = 2'd1,
    RegAverageShift = 2'd2
  } reg_idx_e;

  typedef enum logic [PhaseW-1:0] {
    PhaseLine1 = 2'd0,
    PhaseAtten1 = 2'd1,
    PhaseLine2 = 2'd2,
    PhaseAtten2 = 2'd3
  } phase_e;

  typedef struct packed {
    logic [TickW-1:0]  relay_delay;
    logic [TickW-1:0]  settle_period;
    logic [ShiftW-1:0] average_shift;
  } cfg_t;

  typedef struct packed {
    logic [NumSlots-1:0] relays;   // bit i is the relay of phase i
    logic [PhaseW-1:0]   current_phase;
    logic                value_stored;
    logic [PhaseW-1:0]   stored_slot;
    logic [MvW-1:0]      new_millivolts;
    logic [MvW-1:0]      old_millivolts;
    logic                cycle_done;
  } res_t;

endpackage

// File: hw/rtl/lsrs_in_if.sv
// ----------------------------------------------------------------------------
// lsrs_in_if
// Input channel: one item per tick, raw sample and done-flag clear.
// ----------------------------------------------------------------------------
interface lsrs_in_if import lsrs_pkg::*; ();

  logic            valid;
  logic            ready;
  logic [RawW-1:0] raw_sample;
  logic            clear_done;

  modport source (output valid, output raw_sample, output clear_done, input ready);
  modport sink   (input valid, input raw_sample, input clear_done, output ready);

endinterface

// File: hw/rtl/lsrs_out_if.sv
// ----------------------------------------------------------------------------
// lsrs_out_if
// Result channel: relay drives, phase and measurement report per tick.
// ----------------------------------------------------------------------------
interface lsrs_out_if import lsrs_pkg::*; ();

  logic              valid;
  logic              ready;
  logic              relay_line1;
  logic              relay_atten1;
  logic              relay_line2;
  logic              relay_atten2;
  logic [PhaseW-1:0] current_phase;
  logic              value_stored;
  logic [PhaseW-1:0] stored_slot;
  logic [MvW-1:0]    new_millivolts;
  logic [MvW-1:0]    old_millivolts;
  logic              cycle_done;

  modport source (
    output valid, output relay_line1, output relay_atten1, output relay_line2,
    output relay_atten2, output current_phase, output value_stored,
    output stored_slot, output new_millivolts, output old_millivolts,
    output cycle_done, input ready
  );
  modport sink (
    input valid, input relay_line1, input relay_atten1, input relay_line2,
    input relay_atten2, input current_phase, input value_stored,
    input stored_slot, input new_millivolts, input old_millivolts,
    input cycle_done, output ready
  );

endinterface

// File: hw/rtl/lsrs_cfg_regs.sv
// ----------------------------------------------------------------------------
// lsrs_cfg_regs
// APB register file: relay delay, settle period, average shift.
// ----------------------------------------------------------------------------
module lsrs_cfg_regs import lsrs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[CfgAddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.relay_delay   <= 16'd10;
      cfg_q.settle_period <= 16'd100;
      cfg_q.average_shift <= 3'd4;
    end else if (wr_en) begin
      case (idx)
        RegRelayDelay:   cfg_q.relay_delay   <= pwdata[TickW-1:0];
        RegSettlePeriod: cfg_q.settle_period <= pwdata[TickW-1:0];
        RegAverageShift: cfg_q.average_shift <= pwdata[ShiftW-1:0];
        default: ;  // unmapped, ignored
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegRelayDelay:   prdata = {{(CfgDataW-TickW){1'b0}}, cfg_q.relay_delay};
      RegSettlePeriod: prdata = {{(CfgDataW-TickW){1'b0}}, cfg_q.settle_period};
      RegAverageShift: prdata = {{(CfgDataW-ShiftW){1'b0}}, cfg_q.average_shift};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/loop_sense_relay_sequencer.sv
// ----------------------------------------------------------------------------
// loop_sense_relay_sequencer
// Four-phase loop measurement sequencer: relay timing, sample averaging,
// new/old value store per slot, sticky done flag.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake       payload
//  --------  ---  --------------  -------------------------------------------
//  in_if     in   valid / ready   raw_sample[11:0], clear_done
//  out_if    out  valid / ready   relays x4, current_phase, value_stored,
//                                 stored_slot, new/old_millivolts, cycle_done
//  apb       in   psel/penable    relay_delay, settle_period, average_shift
//
//  Each item passes the input register (sample scaled to mV there), then
//  state update and result register. One item per cycle sustained while
//  the result side is ready. The tick/accumulator state loop closes
//  through its own registers. Reset clears all state, stored values and
//  both pipeline valid bits. A stalled result holds; the input register
//  keeps filling as long as the result register can drain in the same cycle.
// ----------------------------------------------------------------------------
module loop_sense_relay_sequencer import lsrs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  lsrs_in_if.sink             in_if,
  lsrs_out_if.source          out_if,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  cfg_t cfg;

  lsrs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // --- handshake -------------------------------------------------------------
  logic s1_valid_q, out_valid_q;
  logic out_free, s1_adv, in_fire;

  assign out_free     = ~out_valid_q | out_if.ready;
  assign s1_adv       = s1_valid_q & out_free;      // item moves to result reg
  assign in_if.ready  = ~s1_valid_q | out_free;
  assign in_fire      = in_if.valid & in_if.ready;

  // --- input stage: millivolt scaling ---------------------------------------
  logic [RawW+MvShift-1:0] mv_prod;
  logic [MvW-1:0]          s1_mv_q;
  logic                    s1_clr_q;

  assign mv_prod = {{MvShift{1'b0}}, in_if.raw_sample} * {{RawW{1'b0}}, MvMul};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else if (in_fire) s1_valid_q <= 1'b1;
    else if (s1_adv)  s1_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_mv_q  <= mv_prod[RawW+MvShift-1:MvShift];
      s1_clr_q <= in_if.clear_done;
    end
  end

  // --- sequencer state -------------------------------------------------------
  logic [TickW-1:0]    tick_q, tick_d;
  logic [PhaseW-1:0]   phase_q, phase_d;
  logic [AccW-1:0]     acc_q, acc_d;
  logic [SmpCntW-1:0]  smp_q, smp_d;
  logic [NumSlots-1:0] relay_q, relay_d;
  logic                done_q, done_d;
  logic [MvW-1:0]      new_mv_q [NumSlots];

  logic [TickW-1:0]    tick_inc;
  logic [AccW-1:0]     acc_sum;
  logic [SmpCntW-1:0]  smp_inc;
  logic [ShiftW-1:0]   shift;
  logic [SmpCntW-1:0]  smp_target;
  logic [AccW-1:0]     acc_shr;
  logic [MvW-1:0]      avg;
  logic                accum, store;
  logic [NumSlots-1:0] phase_bit;
  res_t                res_d, out_q;

  always_comb begin
    // average_shift 7 saturates to 6
    shift      = (cfg.average_shift > MaxShift) ? MaxShift : cfg.average_shift;
    smp_target = SmpCntW'(1) << shift;
    phase_bit  = NumSlots'(1) << phase_q;

    tick_inc = tick_q + TickW'(1);
    acc_sum  = acc_q + AccW'(s1_mv_q);
    smp_inc  = smp_q + SmpCntW'(1);
    acc_shr  = acc_sum >> shift;
    avg      = acc_shr[MvW-1:0];

    accum = (tick_inc >= cfg.settle_period);
    store = accum & (smp_inc == smp_target);

    // relay pulls in at the delay count; dropped again when the slot is done
    relay_d = relay_q;
    if (tick_inc == cfg.relay_delay) relay_d = relay_d | phase_bit;
    if (store) relay_d = relay_d & ~phase_bit;

    tick_d  = store ? '0 : tick_inc;
    acc_d   = store ? '0 : (accum ? acc_sum : acc_q);
    smp_d   = store ? '0 : (accum ? smp_inc : smp_q);
    phase_d = store ? phase_q + PhaseW'(1) : phase_q;

    // clear goes first, so completing atten2 in the same tick still sets it
    done_d  = (s1_clr_q ? 1'b0 : done_q) | (store & (phase_q == PhaseAtten2));

    // the slot's old value is its new value before this store
    res_d.relays         = relay_d;
    res_d.current_phase  = phase_d;
    res_d.value_stored   = store;
    res_d.stored_slot    = store ? phase_q : '0;
    res_d.new_millivolts = store ? avg : '0;
    res_d.old_millivolts = store ? new_mv_q[phase_q] : '0;
    res_d.cycle_done     = done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      phase_q <= PhaseLine1;
      acc_q   <= '0;
      smp_q   <= '0;
      relay_q <= '0;
      done_q  <= 1'b0;
      for (int i = 0; i < NumSlots; i++) begin
        new_mv_q[i] <= '0;
      end
    end else if (s1_adv) begin
      tick_q  <= tick_d;
      phase_q <= phase_d;
      acc_q   <= acc_d;
      smp_q   <= smp_d;
      relay_q <= relay_d;
      done_q  <= done_d;
      if (store) begin
        new_mv_q[phase_q] <= avg;
      end
    end
  end

  // --- result register -------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (s1_adv)  out_valid_q <= 1'b1;
    else if (out_if.ready) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) out_q <= res_d;
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.relay_line1    = out_q.relays[PhaseLine1];
  assign out_if.relay_atten1   = out_q.relays[PhaseAtten1];
  assign out_if.relay_line2    = out_q.relays[PhaseLine2];
  assign out_if.relay_atten2   = out_q.relays[PhaseAtten2];
  assign out_if.current_phase  = out_q.current_phase;
  assign out_if.value_stored   = out_q.value_stored;
  assign out_if.stored_slot    = out_q.stored_slot;
  assign out_if.new_millivolts = out_q.new_millivolts;
  assign out_if.old_millivolts = out_q.old_millivolts;
  assign out_if.cycle_done     = out_q.cycle_done;

  // --- assertions ------------------------------------------------------------
  // only the current phase's relay can ever be pulled in
  a_relay_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(relay_q))
    else $error("more than one relay on");

  // a finished slot reports its relay already dropped
  a_stored_relay_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.value_stored) |-> (out_q.relays[out_q.stored_slot] == 1'b0))
    else $error("relay still on after its measurement");

  // completing a measurement advances to the next phase
  a_stored_phase_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.value_stored) |->
      (out_q.current_phase == PhaseW'(out_q.stored_slot + PhaseW'(1))))
    else $error("phase did not advance after store");

  // no measurement, report fields are zero
  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.value_stored) |->
      (out_q.stored_slot == '0 && out_q.new_millivolts == '0 &&
       out_q.old_millivolts == '0))
    else $error("report fields set without a measurement");

endmodule

// File: tb/tb_loop_sense_relay_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_loop_sense_relay_sequencer
// Self-checking bench for the loop sense relay sequencer: items go in over
// the input channel, timing is set over APB, and every result is compared
// against an in-bench model of the four-phase measurement sequence.
// ----------------------------------------------------------------------------
module tb_loop_sense_relay_sequencer;
  import lsrs_pkg::*;

  // Timing of the run
  localparam int unsigned TimeoutNs   = 2_000_000;
  localparam int unsigned ResetCycles = 9;
  localparam int unsigned DrainCycles = 6;          // pipeline is 2 deep

  // Millivolt scaling of one raw sample
  localparam int unsigned MvNum = 804;
  localparam int unsigned MvDen = 1000;

  // Register values after reset
  localparam logic [TickW-1:0]  DefRelayDelay   = 16'd10;
  localparam logic [TickW-1:0]  DefSettlePeriod = 16'd100;
  localparam logic [ShiftW-1:0] DefAverageShift = 3'd4;

  // Register slot past the end of the map; writes must be dropped
  localparam logic [1:0] RegUnmapped = 2'd3;

  localparam int unsigned RandRounds        = 8;
  localparam int unsigned RandItemsPerRound = 62;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  lsrs_in_if  in_if ();
  lsrs_out_if out_if ();

  loop_sense_relay_sequencer u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Sequencer model: register copy and measurement state
  // --------------------------------------------------------------------------
  cfg_t                seq_cfg;
  logic [TickW-1:0]    seq_tick;
  phase_e              seq_phase;
  logic [AccW-1:0]     seq_acc;
  logic [SmpCntW-1:0]  seq_samples;
  logic [MvW-1:0]      slot_new_mv [NumSlots];
  logic [MvW-1:0]      slot_old_mv [NumSlots];
  logic [NumSlots-1:0] seq_relays;
  logic                seq_done;

  res_t pending_reports [$];   // reports owed by the DUT, oldest first
  int   error_count = 0;

  // Sender / receiver pacing
  int   burst_left = 0;
  int   rx_mode    = 0;
  int   rx_left    = 0;
  int   rx_count   = 0;
  logic rx_ready   = 1'b0;

  assign out_if.ready = rx_ready;

  // One tick of the sequencer: updates the model, returns the report.
  function automatic res_t step_sequencer(input logic [RawW-1:0] raw, input logic clr);
    res_t              rep;
    phase_e            p;
    logic [ShiftW-1:0] shift;
    logic [MvW-1:0]    mv;
    rep   = '0;
    p     = seq_phase;
    // shift 7 saturates to 6 so at most 64 samples are summed
    shift = (seq_cfg.average_shift > MaxShift) ? MaxShift : seq_cfg.average_shift;
    mv    = MvW'((int'(raw) * MvNum) / MvDen);

    if (clr) seq_done = 1'b0;      // clear goes first, a set in this tick wins

    seq_tick = seq_tick + TickW'(1);    // wraps at 16 bits
    if (seq_tick == seq_cfg.relay_delay) seq_relays[p] = 1'b1;

    // after a wrap, accumulation stalls until the settle point comes again
    if (seq_tick >= seq_cfg.settle_period) begin
      seq_acc     = seq_acc + AccW'(mv);
      seq_samples = seq_samples + SmpCntW'(1);
      if (seq_samples == (SmpCntW'(1) << shift)) begin
        slot_old_mv[p]     = slot_new_mv[p];
        slot_new_mv[p]     = MvW'(seq_acc >> shift);
        rep.value_stored   = 1'b1;
        rep.stored_slot    = p;
        rep.new_millivolts = slot_new_mv[p];
        rep.old_millivolts = slot_old_mv[p];
        seq_acc            = '0;
        seq_samples        = '0;
        seq_tick           = '0;
        seq_relays[p]      = 1'b0;  // dropped even if never switched on
        if (p == PhaseAtten2) seq_done = 1'b1;
        seq_phase = p.next();       // wraps atten2 -> line1
      end
    end

    rep.relays        = seq_relays;
    rep.current_phase = seq_phase;
    rep.cycle_done    = seq_done;
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Send one item; valid stays up between back-to-back items of a burst.
  task automatic send_tick(input logic [RawW-1:0] raw, input logic clr);
    int gap;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    in_if.valid      <= 1'b1;
    in_if.raw_sample <= raw;
    in_if.clear_done <= clr;
    do @(posedge clk_i); while (!in_if.ready);
    pending_reports.push_back(step_sequencer(raw, clr));
    burst_left--;
  endtask

  // Drop valid and hold off until every owed report has come back.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_reports.size() != 0);
  endtask

  // APB write: setup cycle, access until pready, then back to idle.
  task automatic apb_write(input logic [1:0] idx, input logic [CfgDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegRelayDelay:   seq_cfg.relay_delay   = data[TickW-1:0];
      RegSettlePeriod: seq_cfg.settle_period = data[TickW-1:0];
      RegAverageShift: seq_cfg.average_shift = data[ShiftW-1:0];
      default: ;       // unmapped slot, ignored
    endcase
  endtask

  task automatic set_timing(input logic [TickW-1:0] delay, input logic [TickW-1:0] settle,
                            input logic [ShiftW-1:0] shift);
    wait_drained();
    apb_write(RegRelayDelay, CfgDataW'(delay));
    apb_write(RegSettlePeriod, CfgDataW'(settle));
    apb_write(RegAverageShift, CfgDataW'(shift));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset register values: relay of line 1 comes on at tick 10.
  task automatic test_reset_defaults();
    for (int n = 0; n < 12; n++) send_tick(RawW'($urandom_range(0, 4095)), n == 0);
  endtask

  // One sample per measurement, so every tick stores; full-scale and
  // alternating bit patterns, plus clear and set of done in the same tick.
  task automatic test_extreme_samples();
    set_timing(16'd1, 16'd1, 3'd0);
    send_tick(12'hFFF, 1'b0);
    send_tick(12'h000, 1'b0);
    send_tick(12'hAAA, 1'b0);
    send_tick(12'h555, 1'b0);   // atten2 done -> flag set
    send_tick(12'h555, 1'b1);   // flag cleared
    send_tick(12'hAAA, 1'b0);
    send_tick(12'h000, 1'b0);
    send_tick(12'hFFF, 1'b1);   // clear and set together: ends set
  endtask

  // Relay delay past the end of the measurement, inside it, and zero.
  task automatic test_relay_timing();
    set_timing(16'd20, 16'd2, 3'd1);
    repeat (6) send_tick(RawW'($urandom_range(0, 4095)), 1'b0);
    set_timing(16'd3, 16'd2, 3'd2);
    repeat (5) send_tick(RawW'($urandom_range(0, 4095)), 1'b0);
    set_timing(16'd0, 16'd1, 3'd1);
    repeat (4) send_tick(RawW'($urandom_range(0, 4095)), 1'b0);
  endtask

  // Shift 7 acts as 6; settle 0 accumulates every tick; full-scale sum.
  task automatic test_average_saturation();
    set_timing(16'd0, 16'd0, 3'd7);
    repeat (64) send_tick(12'hFFF, 1'b0);
  endtask

  // Unmapped slot is ignored; bits above a register's width are dropped.
  task automatic test_unmapped_register();
    wait_drained();
    apb_write(RegUnmapped, 32'hFFFF_FFFF);
    apb_write(RegRelayDelay, 32'hFFFF_0002);
    apb_write(RegSettlePeriod, 32'h0001_0003);
    apb_write(RegAverageShift, 32'hFFFF_FFF9);
    repeat (10) send_tick(RawW'($urandom_range(0, 4095)), 1'b0);
  endtask

  // Random samples over a series of mostly short timings, with a few
  // extreme ones, and one full drain in the middle of a round.
  task automatic test_random_ticks();
    logic [TickW-1:0]  delay;
    logic [TickW-1:0]  settle;
    logic [ShiftW-1:0] shift;
    for (int round = 0; round < RandRounds; round++) begin
      delay  = TickW'($urandom_range(0, 16));
      settle = TickW'($urandom_range(0, 8));
      shift  = ShiftW'($urandom_range(0, 3));
      if (round == 2) delay = 16'hFFFF;
      if (round == 4) shift = 3'd7;
      if (round == 5) settle = 16'hFFFF;  // never accumulates
      set_timing(delay, settle, shift);
      for (int n = 0; n < RandItemsPerRound; n++) begin
        if (round == 1 && n == RandItemsPerRound / 2) wait_drained();
        send_tick(RawW'($urandom_range(0, 4095)), $urandom_range(0, 9) == 0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: receiver stall pattern and report check
  // --------------------------------------------------------------------------

  // Stall mode changes after a random run: always ready, coin flip,
  // one stall in four, or long stalls.
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 150);
    end else begin
      rx_left--;
    end
    rx_count++;
    case (rx_mode)
      0:       rx_ready <= 1'b1;
      1:       rx_ready <= 1'($urandom_range(0, 1));
      2:       rx_ready <= (rx_count % 4) != 0;
      default: rx_ready <= (rx_count % 16) >= 10;
    endcase
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : report_check
    res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: report with no item pending, expected none actual phase %0d",
                 $time, out_if.current_phase);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("relay_line1", 32'(want.relays[PhaseLine1]), 32'(out_if.relay_line1));
        check_field("relay_atten1", 32'(want.relays[PhaseAtten1]),
                    32'(out_if.relay_atten1));
        check_field("relay_line2", 32'(want.relays[PhaseLine2]), 32'(out_if.relay_line2));
        check_field("relay_atten2", 32'(want.relays[PhaseAtten2]),
                    32'(out_if.relay_atten2));
        check_field("current_phase", 32'(want.current_phase), 32'(out_if.current_phase));
        check_field("value_stored", 32'(want.value_stored), 32'(out_if.value_stored));
        check_field("stored_slot", 32'(want.stored_slot), 32'(out_if.stored_slot));
        check_field("new_millivolts", 32'(want.new_millivolts),
                    32'(out_if.new_millivolts));
        check_field("old_millivolts", 32'(want.old_millivolts),
                    32'(out_if.old_millivolts));
        check_field("cycle_done", 32'(want.cycle_done), 32'(out_if.cycle_done));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    // model starts in its reset state
    seq_cfg.relay_delay   = DefRelayDelay;
    seq_cfg.settle_period = DefSettlePeriod;
    seq_cfg.average_shift = DefAverageShift;
    seq_tick    = '0;
    seq_phase   = PhaseLine1;
    seq_acc     = '0;
    seq_samples = '0;
    seq_relays  = '0;
    seq_done    = 1'b0;
    for (int s = 0; s < NumSlots; s++) begin
      slot_new_mv[s] = '0;
      slot_old_mv[s] = '0;
    end

    // every DUT input known from time zero
    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_if.valid      <= 1'b0;
    in_if.raw_sample <= '0;
    in_if.clear_done <= 1'b0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_extreme_samples();
    test_relay_timing();
    test_average_saturation();
    test_unmapped_register();
    test_random_ticks();

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(TimeoutNs);
    $display("%0t: timeout, %0d reports still pending", $time, pending_reports.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/lsrs_pkg.sv
hw/rtl/lsrs_in_if.sv
hw/rtl/lsrs_out_if.sv
hw/rtl/lsrs_cfg_regs.sv
hw/rtl/loop_sense_relay_sequencer.sv
tb/tb_loop_sense_relay_sequencer.sv
